@@ rtl/core/bfpd_pkg.sv @@
package bfpd_pkg;

  // clamp limits applied to the configuration registers
  localparam int MAX_SIDE_PIX   = 4096;
  localparam int MAX_BLOCK_SIDE = 8;
  localparam int MAX_PLANES     = 4;

  // bit mask value right after a flag byte
  localparam logic [7:0] FIRST_BIT = 8'h80;

  // command queue between front and back
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // configuration register indexes
  localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_BLOCK_SIDE      = 3'd2;
  localparam logic [2:0] REG_BYTES_PER_PIXEL = 3'd3;

  // item kinds; MODE_DONE is what the decoder expects once the image is complete
  typedef enum logic [1:0] {
    MODE_FLAG = 2'd0,
    MODE_FILL = 2'd1,
    MODE_RAW  = 2'd2,
    MODE_DONE = 2'd3
  } mode_t;

  // one queued command: a clipped rectangle painted with one value.
  // raw bytes and errors are 1x1 rectangles.
  typedef struct packed {
    logic        err;
    logic [11:0] x;
    logic [11:0] y;
    logic [3:0]  bw;
    logic [3:0]  bh;
    logic [1:0]  plane;
    logic [7:0]  value;
    logic        done;
  } cmd_t;

  // one result transaction
  typedef struct packed {
    logic        write_valid;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [1:0]  plane;
    logic [7:0]  value;
    logic        last;
    logic        image_done;
    logic        kind_error;
  } res_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/core/bfpd_if.sv @@
interface bfpd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface bfpd_out_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [1:0]  plane;
  logic [7:0]  value;
  logic        last;
  logic        image_done;
  logic        kind_error;

  modport source (output valid, output write_valid, output pos_x, output pos_y,
                  output plane, output value, output last, output image_done,
                  output kind_error, input ready);
  modport sink   (input valid, input write_valid, input pos_x, input pos_y,
                  input plane, input value, input last, input image_done,
                  input kind_error, output ready);
endinterface

@@ rtl/core/bfpd_cmd_fifo.sv @@
module bfpd_cmd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bfpd_pkg::cmd_t   push_cmd,
  input  logic             pop,
  output bfpd_pkg::cmd_t   head_cmd,
  output bfpd_pkg::q_stat_t stat
);
  import bfpd_pkg::*;

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMD_CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  assign head_cmd   = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

@@ rtl/core/bfpd_front.sv @@
module bfpd_front (
  input  logic              clk,
  input  logic              rst_n,
  bfpd_in_if.sink           in_if,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [12:0]       cfg_data,
  input  bfpd_pkg::q_stat_t q_stat,
  output logic              push,
  output bfpd_pkg::cmd_t    push_cmd
);
  import bfpd_pkg::*;

  logic [12:0] width_r, height_r;
  logic [3:0]  side_r;
  logic [2:0]  bpp_r;

  logic [1:0]  plane_r, plane_nxt;
  logic [11:0] bx_r, bx_nxt, by_r, by_nxt;
  logic [2:0]  row_r, row_nxt, col_r, col_nxt;
  logic [7:0]  flag_r, flag_nxt, mask_r, mask_nxt;
  logic        fin_r, fin_nxt;

  logic [12:0] w, h, rem_w, rem_h;
  logic [3:0]  s, bw, bh;
  logic [2:0]  planes;
  mode_t       expected, mode;
  logic        take, adv, done;

  // clamped working copies of the registers
  always_comb begin
    w = (width_r == '0) ? 13'd1 :
        (width_r > 13'(MAX_SIDE_PIX)) ? 13'(MAX_SIDE_PIX) : width_r;
    h = (height_r == '0) ? 13'd1 :
        (height_r > 13'(MAX_SIDE_PIX)) ? 13'(MAX_SIDE_PIX) : height_r;
    s = (side_r == '0) ? 4'd1 :
        (side_r > 4'(MAX_BLOCK_SIDE)) ? 4'(MAX_BLOCK_SIDE) : side_r;
    planes = (bpp_r == '0) ? 3'd1 :
             (bpp_r > 3'(MAX_PLANES)) ? 3'(MAX_PLANES) : bpp_r;
  end

  assign in_if.ready = !q_stat.full;
  assign take        = in_if.valid && in_if.ready;
  assign mode        = mode_t'(in_if.mode);

  always_comb begin
    rem_w = w - {1'b0, bx_r};
    rem_h = h - {1'b0, by_r};
    bw    = (rem_w < {9'd0, s}) ? rem_w[3:0] : s;
    bh    = (rem_h < {9'd0, s}) ? rem_h[3:0] : s;

    if (fin_r)              expected = MODE_DONE;
    else if (mask_r == '0)  expected = MODE_FLAG;
    else if ((flag_r & mask_r) != '0) expected = MODE_FILL;
    else                    expected = MODE_RAW;

    plane_nxt = plane_r;
    bx_nxt    = bx_r;
    by_nxt    = by_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    flag_nxt  = flag_r;
    mask_nxt  = mask_r;
    fin_nxt   = fin_r;
    push      = 1'b0;
    push_cmd  = '0;
    adv       = 1'b0;
    done      = 1'b0;

    if (take) begin
      if (mode != expected) begin
        push        = 1'b1;
        push_cmd.err = 1'b1;
        push_cmd.bw  = 4'd1;
        push_cmd.bh  = 4'd1;
      end else begin
        case (mode)
          MODE_FLAG: begin
            flag_nxt = in_if.data_byte;
            mask_nxt = FIRST_BIT;
          end
          MODE_FILL: begin
            push           = 1'b1;
            push_cmd.x     = bx_r;
            push_cmd.y     = by_r;
            push_cmd.bw    = bw;
            push_cmd.bh    = bh;
            push_cmd.plane = plane_r;
            push_cmd.value = in_if.data_byte;
            adv            = 1'b1;
          end
          default: begin
            // raw byte, also taken after the image is done
            push           = 1'b1;
            push_cmd.x     = bx_r + 12'(col_r);
            push_cmd.y     = by_r + 12'(row_r);
            push_cmd.bw    = 4'd1;
            push_cmd.bh    = 4'd1;
            push_cmd.plane = plane_r;
            push_cmd.value = in_if.data_byte;
            if ({1'b0, col_r} + 4'd1 >= bw) begin
              col_nxt = '0;
              if ({1'b0, row_r} + 4'd1 >= bh) adv = 1'b1;
              else row_nxt = row_r + 1'b1;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
        endcase
      end

      // step to the next block in raster order
      if (adv) begin
        mask_nxt = mask_r >> 1;
        row_nxt  = '0;
        col_nxt  = '0;
        if ({1'b0, bx_r} + 13'(s) < w) begin
          bx_nxt = bx_r + 12'(s);
        end else begin
          bx_nxt = '0;
          if ({1'b0, by_r} + 13'(s) < h) begin
            by_nxt = by_r + 12'(s);
          end else begin
            by_nxt   = '0;
            mask_nxt = '0;
            if ({1'b0, plane_r} + 3'd1 < planes) begin
              plane_nxt = plane_r + 1'b1;
            end else begin
              plane_nxt = '0;
              fin_nxt   = 1'b1;
              done      = 1'b1;
            end
          end
        end
        push_cmd.done = done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd1;
      height_r <= 13'd1;
      side_r   <= 4'd8;
      bpp_r    <= 3'd4;
      plane_r  <= '0;
      bx_r     <= '0;
      by_r     <= '0;
      row_r    <= '0;
      col_r    <= '0;
      flag_r   <= '0;
      mask_r   <= '0;
      fin_r    <= 1'b0;
    end else if (cfg_we && cfg_index <= REG_BYTES_PER_PIXEL) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: height_r <= cfg_data;
        REG_BLOCK_SIDE:   side_r   <= cfg_data[3:0];
        default:          bpp_r    <= cfg_data[2:0];
      endcase
      // a write to any defined register restarts decoding
      plane_r <= '0;
      bx_r    <= '0;
      by_r    <= '0;
      row_r   <= '0;
      col_r   <= '0;
      flag_r  <= '0;
      mask_r  <= '0;
      fin_r   <= 1'b0;
    end else begin
      plane_r <= plane_nxt;
      bx_r    <= bx_nxt;
      by_r    <= by_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      flag_r  <= flag_nxt;
      mask_r  <= mask_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

@@ rtl/core/bfpd_back.sv @@
module bfpd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  bfpd_pkg::cmd_t    head_cmd,
  input  bfpd_pkg::q_stat_t q_stat,
  output logic              pop,
  bfpd_out_if.source        out_if
);
  import bfpd_pkg::*;

  logic       busy_r, busy_nxt;
  cmd_t       cur_r, cur_nxt, src;
  logic [2:0] j_r, j_nxt, i_r, i_nxt, j, i;
  logic       out_valid_r, out_valid_nxt;
  res_t       out_r, out_nxt;
  logic       src_valid, emit, col_end, row_end;

  always_comb begin
    src       = busy_r ? cur_r : head_cmd;
    j         = busy_r ? j_r : 3'd0;
    i         = busy_r ? i_r : 3'd0;
    src_valid = busy_r || !q_stat.empty;
    emit      = src_valid && (!out_valid_r || out_if.ready);
    pop       = emit && !busy_r;
    col_end   = ({1'b0, j} + 4'd1 == src.bw);
    row_end   = ({1'b0, i} + 4'd1 == src.bh);

    busy_nxt      = busy_r;
    cur_nxt       = cur_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_if.ready;

    if (emit) begin
      out_valid_nxt          = 1'b1;
      out_nxt.write_valid    = !src.err;
      out_nxt.pos_x          = src.x + 12'(j);
      out_nxt.pos_y          = src.y + 12'(i);
      out_nxt.plane          = src.plane;
      out_nxt.value          = src.value;
      out_nxt.last           = col_end && row_end;
      out_nxt.image_done     = src.done && col_end && row_end;
      out_nxt.kind_error     = src.err;
      cur_nxt                = src;
      if (col_end && row_end) begin
        busy_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b1;
        if (col_end) begin
          j_nxt = '0;
          i_nxt = i + 1'b1;
        end else begin
          j_nxt = j + 1'b1;
          i_nxt = i;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    j_r   <= j_nxt;
    i_r   <= i_nxt;
    out_r <= out_nxt;
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.write_valid = out_r.write_valid;
  assign out_if.pos_x       = out_r.pos_x;
  assign out_if.pos_y       = out_r.pos_y;
  assign out_if.plane       = out_r.plane;
  assign out_if.value       = out_r.value;
  assign out_if.last        = out_r.last;
  assign out_if.image_done  = out_r.image_done;
  assign out_if.kind_error  = out_r.kind_error;

endmodule

@@ rtl/core/block_fill_plane_decoder_top.sv @@
// channel  dir  handshake          payload
// in_if    in   valid/ready        mode[1:0], data_byte[7:0]
// out_if   out  valid/ready        write_valid, pos_x, pos_y, plane, value,
//                                  last, image_done, kind_error
// cfg_*    in   cfg_we (no wait)   cfg_index[2:0], cfg_data[12:0]
//
// One input transaction per cycle while the command queue has room.
// Raw bytes and errors give one result each; results leave one per cycle
// while out_if does not stall. A fill byte gives one result per pixel of
// its clipped block (up to 64), holding the back end while the front queues.
// Results pass through the command queue, then the output register.
// rst_n is synchronous; registers return to width 1, height 1, side 8,
// four planes, decoding at plane 0 waiting for a flag byte.
// Stalls on out_if back up into the queue, then into in_if.ready.
module block_fill_plane_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  bfpd_in_if.sink     in_if,
  bfpd_out_if.source  out_if,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import bfpd_pkg::*;

  // front -> queue -> back
  logic    push, pop;
  cmd_t    push_cmd, head_cmd;
  q_stat_t q_stat;

  // front: register file, block walker, item classification
  bfpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // short command queue decouples input from fill expansion
  bfpd_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head_cmd(head_cmd),
    .stat    (q_stat)
  );

  // back: expands each rectangle into pixel writes through an output register
  bfpd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head_cmd(head_cmd),
    .q_stat  (q_stat),
    .pop     (pop),
    .out_if  (out_if)
  );

endmodule

@@ dv/block_fill_plane_decoder_top_tb.sv @@
// Block fill plane decoder testbench.
//
// The stimulus process walks a short directed plan first. The plan covers reset
// defaults, every item kind, wrong-kind items while a flag, a raw byte or the
// done kind is due, items after image completion, and clamped register values.
// Random register settings follow, each decoding a mostly well-formed image with
// some noise mixed in. Two short runs at the 4096-pixel extent come last.
// Every accepted input transaction goes through an in-house model of the
// decoder. Its results, or a result written by hand for some plan rows, are
// queued and compared field by field against the output channel.

module block_fill_plane_decoder_top_tb;
  import bfpd_pkg::*;

  // one row of the directed plan: a register write or an input transaction,
  // optionally with its single result spelled out by hand
  typedef struct packed {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [12:0] val;
    mode_t       m;
    logic [7:0]  b;
    bit          typed;
    res_t        want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;

  bfpd_in_if  in_if();
  bfpd_out_if out_if();

  block_fill_plane_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder model: register copies and walk state, at reset values
  // ---------------------------------------------------------------------------
  logic [12:0] r_width  = 13'd1;
  logic [12:0] r_height = 13'd1;
  logic [3:0]  r_side   = 4'd8;
  logic [2:0]  r_bpp    = 3'd4;

  // counters kept as ints; in-block offsets reach 8 before they wrap
  int         pl = 0, bcol = 0, brow = 0, rin = 0, cin = 0;
  logic [7:0] flags = 8'h00;
  logic [7:0] mask  = 8'h00;   // zero while a flag byte is due
  bit         fin   = 1'b0;

  res_t due_writes[$];   // results still owed by the block, oldest first
  res_t step_res[$];     // results of the item just decoded by the model

  int fails = 0, items_sent = 0, useful = 0, checked = 0;
  int kind_errs = 0, images = 0, reg_writes = 0;
  bit quiet = 1'b0;      // suppresses idling on both channels

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic res_t wr(int x, int y, int p, logic [7:0] v);
    res_t r;
    r = '0;
    r.write_valid = 1'b1;
    r.pos_x       = 12'(x);
    r.pos_y       = 12'(y);
    r.plane       = 2'(p);
    r.value       = v;
    return r;
  endfunction

  function automatic res_t err_res();
    res_t r;
    r = '0;
    r.kind_error = 1'b1;
    r.last       = 1'b1;
    return r;
  endfunction

  // kind the decoder is waiting for in its current state
  function automatic mode_t want_mode();
    if (fin) return MODE_DONE;
    if (mask == 8'h00) return MODE_FLAG;
    return ((flags & mask) != 8'h00) ? MODE_FILL : MODE_RAW;
  endfunction

  // step to the next block in raster order; 1 when the last plane wraps
  function automatic bit advance_block(int w, int h, int s, int np);
    int ncols, nrows;
    ncols = (w + s - 1) / s;
    nrows = (h + s - 1) / s;
    mask = mask >> 1;
    rin = 0;
    cin = 0;
    bcol++;
    if (bcol < ncols) return 1'b0;
    bcol = 0;
    brow++;
    if (brow < nrows) return 1'b0;
    brow = 0;
    mask = 8'h00;
    pl++;
    if (pl < np) return 1'b0;
    pl  = 0;
    fin = 1'b1;
    return 1'b1;
  endfunction

  // decode one accepted item into step_res and advance the model
  function automatic void paint_item(mode_t m, logic [7:0] b);
    int   w, h, s, np, bx, by, bw, bh;
    bit   done;
    res_t tail;
    step_res.delete();
    w  = clampi(r_width, 1, MAX_SIDE_PIX);
    h  = clampi(r_height, 1, MAX_SIDE_PIX);
    s  = clampi(r_side, 1, MAX_BLOCK_SIDE);
    np = clampi(r_bpp, 1, MAX_PLANES);
    if (m != want_mode()) begin
      step_res.push_back(err_res());
      return;
    end
    if (m == MODE_FLAG) begin
      flags = b;
      mask  = FIRST_BIT;
      return;
    end
    bx = bcol * s;
    by = brow * s;
    bw = (w - bx < s) ? w - bx : s;
    bh = (h - by < s) ? h - by : s;
    done = 1'b0;
    if (m == MODE_FILL) begin
      for (int i = 0; i < bh; i++)
        for (int j = 0; j < bw; j++)
          step_res.push_back(wr(bx + j, by + i, pl, b));
      done = advance_block(w, h, s, np);
    end else begin
      // raw byte, or the done kind once the image is complete
      step_res.push_back(wr(bx + cin, by + rin, pl, b));
      cin++;
      if (cin >= bw) begin
        cin = 0;
        rin++;
        if (rin >= bh) done = advance_block(w, h, s, np);
      end
    end
    tail = step_res.pop_back();
    tail.last       = 1'b1;
    tail.image_done = done;
    step_res.push_back(tail);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    fails++;
    if (fails <= 40) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                checked, name, got, want));
  endtask

  // Samples the output channel right after each edge (pre-edge values) and
  // drives the sink ready with random stalls.
  always @(posedge clk) begin : watch
    res_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.write_valid, out_if.pos_x, out_if.pos_y, out_if.plane,
             out_if.value, out_if.last, out_if.image_done, out_if.kind_error};
      if (due_writes.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = due_writes.pop_front();
        checked++;
        check_field("write_valid", got.write_valid, want.write_valid);
        check_field("pos_x",       got.pos_x,       want.pos_x);
        check_field("pos_y",       got.pos_y,       want.pos_y);
        check_field("plane",       got.plane,       want.plane);
        check_field("value",       got.value,       want.value);
        check_field("last",        got.last,        want.last);
        check_field("image_done",  got.image_done,  want.image_done);
        check_field("kind_error",  got.kind_error,  want.kind_error);
      end
    end
    out_if.ready <= quiet || ($urandom_range(0, 99) >= 11);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // One input transaction. valid is only lowered inside an idle gap, so a
  // back-to-back item never sees valid lowered and raised in the same step.
  task automatic send_item(mode_t m, logic [7:0] b, bit typed, res_t want);
    cfg_we <= 1'b0;
    while (!quiet && $urandom_range(0, 99) < 11) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.mode      <= m;
    in_if.data_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    paint_item(m, b);
    if (typed) due_writes.push_back(want);
    else foreach (step_res[i]) due_writes.push_back(step_res[i]);
    items_sent++;
    if (step_res.size() != 0 && step_res[0].kind_error) kind_errs++;
    else useful++;
    if (step_res.size() != 0 && step_res[step_res.size() - 1].image_done) images++;
  endtask

  // Let the block go idle: every owed result out, then a further wait in case
  // a flag byte (no result) is still in flight.
  task automatic settle();
    in_if.valid <= 1'b0;
    cfg_we      <= 1'b0;
    while (due_writes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write; a write to a defined register restarts decoding at
  // plane 0, block 0.
  task automatic write_reg(logic [2:0] idx, logic [12:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_IMAGE_WIDTH:     r_width  = val;
      REG_IMAGE_HEIGHT:    r_height = val;
      REG_BLOCK_SIDE:      r_side   = val[3:0];
      REG_BYTES_PER_PIXEL: r_bpp    = val[2:0];
      default: ;
    endcase
    if (idx <= REG_BYTES_PER_PIXEL) begin
      pl = 0; bcol = 0; brow = 0; rin = 0; cin = 0;
      flags = 8'h00; mask = 8'h00; fin = 1'b0;
    end
    reg_writes++;
    @(posedge clk);
  endtask

  // Drive the kind the model expects, with noise_pct percent random kinds.
  // flag_kind: 0 random flags, 1 fill-heavy flags, 2 all-fill flags.
  // After the image completes a few more items probe the done state.
  task automatic run_image(int budget, int noise_pct, int flag_kind);
    mode_t      m;
    logic [7:0] b;
    for (int k = 0; k < budget; k++) begin
      if (fin && $urandom_range(0, 2) == 0) break;
      if ($urandom_range(0, 99) < noise_pct) m = mode_t'(2'($urandom_range(0, 3)));
      else m = want_mode();
      b = 8'($urandom_range(0, 255));
      if (m == MODE_FLAG && flag_kind == 1) b = b | 8'($urandom_range(0, 255));
      if (m == MODE_FLAG && flag_kind == 2) b = 8'hFF;
      send_item(m, b, 1'b0, '0);
    end
  endtask

  function automatic logic [12:0] pick_size();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return 13'd0;                              // clamps up to 1
    if (k == 1) return 13'($urandom_range(4096, 8191));    // clamps to the max
    return 13'($urandom_range(1, 8));
  endfunction

  function automatic step_t cfg_row(logic [2:0] idx, logic [12:0] val);
    step_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  function automatic step_t item_row(mode_t m, logic [7:0] b);
    step_t r;
    r = '0;
    r.m = m;
    r.b = b;
    return r;
  endfunction

  function automatic step_t err_row(mode_t m, logic [7:0] b);
    step_t r;
    r = item_row(m, b);
    r.typed = 1'b1;
    r.want  = err_res();
    return r;
  endfunction

  // single-pixel write that ends the item, result written out by hand
  function automatic step_t hit_row(mode_t m, logic [7:0] b, int p, bit done);
    step_t r;
    r = item_row(m, b);
    r.typed = 1'b1;
    r.want  = wr(0, 0, p, b);
    r.want.last       = 1'b1;
    r.want.image_done = done;
    return r;
  endfunction

  initial begin
    step_t plan[$];
    int    useful_base;
    int    phases;

    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.mode      = MODE_FLAG;
    in_if.data_byte = 8'h00;
    out_if.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_IMAGE_WIDTH;
    cfg_data        = 13'd0;
    phases          = 0;

    // Directed plan. Reset config is a 1x1 image with four planes, so each
    // plane is one block holding one pixel at (0,0).
    plan.push_back(err_row(MODE_RAW,  8'h00));   // flag due, raw sent
    plan.push_back(err_row(MODE_DONE, 8'hFF));   // done kind before done
    plan.push_back(err_row(MODE_FILL, 8'h00));
    plan.push_back(item_row(MODE_FLAG, 8'h80));
    plan.push_back(hit_row(MODE_FILL, 8'h00, 0, 1'b0));
    plan.push_back(item_row(MODE_FLAG, 8'h00));  // new plane needs a new flag
    plan.push_back(hit_row(MODE_RAW,  8'hFF, 1, 1'b0));
    plan.push_back(item_row(MODE_FLAG, 8'hFF));
    plan.push_back(hit_row(MODE_FILL, 8'h5A, 2, 1'b0));
    plan.push_back(item_row(MODE_FLAG, 8'h7F));
    plan.push_back(err_row(MODE_FILL, 8'h33));   // raw due, fill sent
    plan.push_back(hit_row(MODE_RAW,  8'hA5, 3, 1'b1));
    plan.push_back(err_row(MODE_FLAG, 8'h01));   // image already complete
    plan.push_back(item_row(MODE_DONE, 8'h3C));  // done kind accepted after done
    // out-of-range values: width and side clamp to max, height to 1, planes to 4
    plan.push_back(cfg_row(REG_IMAGE_WIDTH,     13'h1FFF));
    plan.push_back(cfg_row(REG_IMAGE_HEIGHT,    13'h0000));
    plan.push_back(cfg_row(REG_BLOCK_SIDE,      13'h000F));
    plan.push_back(cfg_row(REG_BYTES_PER_PIXEL, 13'h0007));
    plan.push_back(item_row(MODE_FLAG, 8'hAA));
    plan.push_back(item_row(MODE_FILL, 8'hC3));  // 8x1 block
    plan.push_back(item_row(MODE_RAW,  8'h01));
    plan.push_back(err_row(MODE_DONE, 8'h00));   // mid-block wrong kind
    plan.push_back(cfg_row(REG_BLOCK_SIDE,      13'h0000));  // side clamps to 1
    plan.push_back(item_row(MODE_FLAG, 8'hFF));
    plan.push_back(item_row(MODE_FILL, 8'h80));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i - 1].is_cfg) settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_item(plan[i].m, plan[i].b, plan[i].typed, plan[i].want);
      end
    end

    // Random part: small images with random clamping. Every sixth phase
    // runs without idling. Short budgets leave some images unfinished.
    useful_base = useful;
    while (useful - useful_base < 200) begin
      settle();
      quiet = (phases % 6 == 4);
      write_reg(REG_IMAGE_WIDTH,     pick_size());
      write_reg(REG_IMAGE_HEIGHT,    pick_size());
      write_reg(REG_BLOCK_SIDE,      13'($urandom_range(0, 15)));
      write_reg(REG_BYTES_PER_PIXEL, 13'($urandom_range(0, 7)));
      run_image($urandom_range(20, 200), 8, $urandom_range(0, 1));
      phases++;
    end
    quiet = 1'b0;

    // Opening fill blocks of a full-width row, no idling anywhere.
    settle();
    quiet = 1'b1;
    write_reg(REG_IMAGE_WIDTH,     13'd4096);
    write_reg(REG_IMAGE_HEIGHT,    13'd1);
    write_reg(REG_BLOCK_SIDE,      13'd8);
    write_reg(REG_BYTES_PER_PIXEL, 13'd1);
    run_image(60, 0, 2);
    quiet = 1'b0;

    // Opening blocks of a full-height column, with idling back on.
    settle();
    write_reg(REG_IMAGE_WIDTH,     13'd1);
    write_reg(REG_IMAGE_HEIGHT,    13'd4096);
    write_reg(REG_BLOCK_SIDE,      13'd8);
    write_reg(REG_BYTES_PER_PIXEL, 13'd1);
    run_image(60, 0, 2);

    settle();

    $display("Sent %0d input transactions (%0d decoded, %0d wrong kind), %0d register writes,",
             items_sent, useful, kind_errs, reg_writes);
    $display("%0d random settings; checked %0d result transactions, %0d complete images.",
             phases, checked, images);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/bfpd_pkg.sv
rtl/core/bfpd_if.sv
rtl/core/bfpd_cmd_fifo.sv
rtl/core/bfpd_front.sv
rtl/core/bfpd_back.sv
rtl/core/block_fill_plane_decoder_top.sv
dv/block_fill_plane_decoder_top_tb.sv
